// File: hdl/mqsb_pkg.sv
// mqsb_pkg: shared types and constants for the multi-queue shared buffer.
// Field widths, command and status codes, controller state and the
// command/status structs between controller and datapath. No dependencies.
package mqsb_pkg;

   // Item field widths
   localparam int CMD_W      = 1;
   localparam int QID_W      = 2;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int REQ_USER_W = CMD_W + QID_W;
   localparam int RSP_USER_W = STATUS_W;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_POP,
      S_WAIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take;        // latch item, read head/tail and free-list link
      logic fetch;       // pointers are back: commit push, refuse, or start pop read
      logic pop_commit;  // link and data of head slot are back: finish pop
      logic emit_held;   // move held result into output register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pop_go;      // item is a pop on a non-empty queue
      logic out_free;    // output register can take a result this cycle
   } dp_status_type;

endpackage

// File: hdl/mqsb_ram.sv
// mqsb_ram: generic single-write, single-read RAM with registered read data.
// Used for data, link, head and tail stores. No dependencies.
module mqsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mqsb_ctrl.sv
// mqsb_ctrl: controller state machine for the multi-queue shared buffer.
// Sequences accept, pointer fetch, pop read and result hand-off.
// Depends on mqsb_pkg.
module mqsb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  mqsb_pkg::dp_status_type stat,
   output mqsb_pkg::ctl_cmd_type   cmd
);

   import mqsb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (stat.pop_go) begin
               state_in = S_POP;
            end else if (stat.out_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_POP: begin
            state_in = stat.out_free ? S_IDLE : S_WAIT;
         end
         S_WAIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
         end
         S_POP: begin
            cmd.pop_commit = 1'b1;
         end
         S_WAIT: begin
            cmd.emit_held = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // A pop commit always follows the pointer fetch of the same item
   a_pop_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> ($past(state_ff) == S_FETCH))
      else $error("pop commit not preceded by fetch");

endmodule

// File: hdl/mqsb_datapath.sv
// mqsb_datapath: stores, pointers, free list and result register of the
// multi-queue shared buffer. Instantiates mqsb_ram; depends on mqsb_pkg.
module mqsb_datapath #(
   parameter int ENTRIES    = 64,
   parameter int QUEUES     = 4,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mqsb_pkg::ctl_cmd_type             cmd,
   output mqsb_pkg::dp_status_type           stat,
   input  logic [mqsb_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic [mqsb_pkg::VALUE_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mqsb_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic [mqsb_pkg::VALUE_W-1:0]      rsp_tdata
);

   import mqsb_pkg::*;

   localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int FCW   = $clog2(ENTRIES + 1);

   // Link of a slot: slots at or above the fill mark were never written
   // and read as their start link, the next slot with wrap, not the RAM word.
   function automatic logic [PTR_W-1:0] link_next(input logic [PTR_W-1:0] idx,
                                                  input logic [PTR_W-1:0] rd,
                                                  input logic [FCW-1:0]   mark);
      logic [PTR_W-1:0] succ;
      succ = (idx == PTR_W'(ENTRIES - 1)) ? '0 : idx + PTR_W'(1);
      return (FCW'(idx) >= mark) ? succ : rd;
   endfunction

   // Item registers
   logic [CMD_W-1:0]   item_cmd_ff;
   logic [QID_W-1:0]   item_q_ff;
   logic [VALUE_W-1:0] item_value_ff;

   // Free list and queue state
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [FCW-1:0]    free_count_ff, free_count_in;
   logic [FCW-1:0]    fill_mark_ff, fill_mark_in;
   logic [QUEUES-1:0] head_valid_ff, head_valid_in;

   // Result registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] hold_status_ff;
   logic [VALUE_W-1:0]  hold_value_ff;

   // RAM ports
   logic [PTR_W-1:0]      head_rd, tail_rd, link_rd;
   logic [DATA_WIDTH-1:0] data_rd;
   logic                  head_we, tail_we, link_we, data_we, link_re;
   logic [PTR_W-1:0]      head_wdata, link_waddr, link_raddr;
   logic [QW-1:0]         q_addr, req_q_addr;

   // Decode
   logic                is_push, in_range, q_valid, push_ok, pop_go;
   logic                push_commit, finish, out_free, out_load;
   logic [STATUS_W-1:0] res_status;
   logic [VALUE_W-1:0]  res_value;

   assign req_q_addr = QW'(req_tuser[CMD_W +: QID_W]);
   assign q_addr     = QW'(item_q_ff);
   assign is_push    = (item_cmd_ff == CMD_PUSH);
   assign in_range   = (32'(item_q_ff) < QUEUES);
   assign q_valid    = in_range && head_valid_ff[q_addr];
   assign push_ok    = is_push && in_range && (free_count_ff != '0);
   assign pop_go     = !is_push && q_valid;
   assign push_commit = cmd.fetch && push_ok;
   assign finish     = (cmd.fetch && !pop_go) || cmd.pop_commit;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = out_free && (finish || cmd.emit_held);

   assign stat.pop_go   = pop_go;
   assign stat.out_free = out_free;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_cmd_ff   <= req_tuser[0 +: CMD_W];
         item_q_ff     <= req_tuser[CMD_W +: QID_W];
         item_value_ff <= req_tdata;
      end
   end

   // RAM control
   assign link_re    = cmd.take || (cmd.fetch && pop_go);
   assign link_raddr = cmd.take ? free_head_ff : head_rd;
   assign link_we    = (push_commit && q_valid) || cmd.pop_commit;
   assign link_waddr = cmd.pop_commit ? head_rd : tail_rd;
   assign head_we    = (push_commit && !q_valid) ||
                       (cmd.pop_commit && (head_rd != tail_rd));
   assign head_wdata = cmd.pop_commit ? link_next(head_rd, link_rd, fill_mark_ff)
                                      : free_head_ff;
   assign tail_we    = push_commit;
   assign data_we    = push_commit;

   mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (free_head_ff),
      .wr_data (DATA_WIDTH'(item_value_ff)),
      .rd_en   (cmd.fetch && pop_go),
      .rd_addr (head_rd),
      .rd_data (data_rd)
   );

   mqsb_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (free_head_ff),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   mqsb_ram #(.WIDTH(PTR_W), .DEPTH(QUEUES)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (q_addr),
      .wr_data (head_wdata),
      .rd_en   (cmd.take),
      .rd_addr (req_q_addr),
      .rd_data (head_rd)
   );

   mqsb_ram #(.WIDTH(PTR_W), .DEPTH(QUEUES)) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (q_addr),
      .wr_data (free_head_ff),
      .rd_en   (cmd.take),
      .rd_addr (req_q_addr),
      .rd_data (tail_rd)
   );

   // Free list, fill mark and queue valid bits
   always_comb begin
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      fill_mark_in  = fill_mark_ff;
      head_valid_in = head_valid_ff;
      if (push_commit) begin
         free_head_in  = link_next(free_head_ff, link_rd, fill_mark_ff);
         free_count_in = free_count_ff - FCW'(1);
         if (FCW'(free_head_ff) >= fill_mark_ff) begin
            fill_mark_in = fill_mark_ff + FCW'(1);
         end
         head_valid_in[q_addr] = 1'b1;
      end else if (cmd.pop_commit) begin
         free_head_in = head_rd;
         if (free_count_ff < FCW'(ENTRIES)) begin
            free_count_in = free_count_ff + FCW'(1);
         end
         if (head_rd == tail_rd) begin
            head_valid_in[q_addr] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_count_ff <= FCW'(ENTRIES);
         fill_mark_ff  <= '0;
         head_valid_ff <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fill_mark_ff  <= fill_mark_in;
         head_valid_ff <= head_valid_in;
      end
   end

   // Result of the finishing step
   always_comb begin
      if (cmd.pop_commit) begin
         res_status = STATUS_DONE;
      end else if (is_push) begin
         res_status = push_ok ? STATUS_DONE : STATUS_FULL;
      end else begin
         res_status = STATUS_EMPTY;
      end
      res_value = cmd.pop_commit ? VALUE_W'(data_rd) : '0;
   end

   // Held copy for when the output register is still occupied
   always_ff @(posedge clock) begin
      if (finish) begin
         hold_status_ff <= res_status;
         hold_value_ff  <= res_value;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.emit_held ? hold_status_ff : res_status;
         rsp_value_in  = cmd.emit_held ? hold_value_ff : res_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_value_ff;

   // Free count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FCW'(ENTRIES))
      else $error("free count above store size");

   // With every queue empty, every slot is back on the free list
   a_all_free: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff == '0) |-> (free_count_ff == FCW'(ENTRIES)))
      else $error("slots lost with all queues empty");

   // A pop only commits against a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_commit |-> q_valid)
      else $error("pop commit on empty queue");

endmodule

// File: hdl/multi_queue_shared_buffer_unit.sv
// Multi-queue shared buffer: QUEUES FIFO queues kept as linked lists in
// one data store of ENTRIES words, with a free list of unused slots.
// Input channel req_*: tuser holds the command (push or pop) and queue id,
// tdata the word to push. Result channel rsp_*: one item per input item,
// tuser holds status (done, store full, queue empty), tdata the popped
// word, zero for pushes and refused pops.
// A push or a refused item finishes in the fetch state and its result
// goes to the output register; a successful pop goes on through the pop
// state first, since it needs the head pointer before it can read the
// head slot's link and data from the registered-read RAMs.
// One item is in work at a time: a new item is taken only after the last
// one has finished, and req_tready is high while the controller is idle.
// A stalled receiver: the finished result sits in the output register and
// the next item is still accepted and worked; that item's result is held
// and the block waits until the output register frees.
// Reset: all queues empty, all slots free. Slot links start as "next
// slot" through a fill mark, so no clearing pass is needed and the block
// accepts items right after reset. Depends on mqsb_pkg, mqsb_ctrl,
// mqsb_datapath, mqsb_ram.
module multi_queue_shared_buffer_unit #(
   parameter int ENTRIES    = 64,
   parameter int QUEUES     = 4,
   parameter int DATA_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mqsb_pkg::VALUE_W-1:0]    req_tdata,   // [31:0] push_value
   input  logic [mqsb_pkg::REQ_USER_W-1:0] req_tuser,   // [0] command, [2:1] queue_id
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mqsb_pkg::VALUE_W-1:0]    rsp_tdata,   // [31:0] pop_value
   output logic [mqsb_pkg::RSP_USER_W-1:0] rsp_tuser    // [1:0] status
);

   import mqsb_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type stat;

   mqsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mqsb_datapath #(
      .ENTRIES    (ENTRIES),
      .QUEUES     (QUEUES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
